// ===== hdl/fra_pkg.sv =====
// ----------------------------------------------------------------------------
// fra_pkg
// Widths and constants shared by the frame rate averaging block.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int unsigned TickW     = 32;
  localparam int unsigned FtW       = 16;
  localparam int unsigned RateW     = 25;
  localparam int unsigned RateScale = 256000;

  localparam logic [FtW-1:0]   FtMax   = {FtW{1'b1}};
  localparam logic [RateW-1:0] RateMax = {RateW{1'b1}};

  typedef logic [TickW-1:0] tick_t;
  typedef logic [FtW-1:0]   ft_t;
  typedef logic [RateW-1:0] rate_t;

endpackage

// ===== hdl/fra_if.sv =====
// ----------------------------------------------------------------------------
// fra_in_if / fra_out_if
// Valid/ready channels for timestamps in and frame statistics out.
// ----------------------------------------------------------------------------
interface fra_in_if import fra_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t tick_ms;

  modport source (output valid, output tick_ms, input ready);
  modport sink   (input valid, input tick_ms, output ready);
endinterface

interface fra_out_if import fra_pkg::*; ();
  logic  valid;
  logic  ready;
  ft_t   frame_time_ms;
  rate_t rate_q8;

  modport source (output valid, output frame_time_ms, output rate_q8, input ready);
  modport sink   (input valid, input frame_time_ms, input rate_q8, output ready);
endinterface

// ===== hdl/fra_diff.sv =====
// ----------------------------------------------------------------------------
// fra_diff
// Bit-serial timestamp difference, saturated to the frame time width.
// ----------------------------------------------------------------------------
module fra_diff import fra_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  tick_t tick_i,
  output logic  done_o,
  output ft_t   ft_o
);

  localparam int unsigned CntW = $clog2(TickW);

  tick_t           tick_q;
  tick_t           last_q;
  ft_t             diff_q;
  ft_t             ft_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic            borrow_q;
  logic            hi_q;
  logic            seen_q;
  logic            first_q;

  logic a_bit, b_bit, d_bit, borrow_d;

  assign a_bit    = tick_q[0];
  assign b_bit    = last_q[0];
  assign d_bit    = a_bit ^ b_bit ^ borrow_q;
  assign borrow_d = (~a_bit & b_bit) | (~a_bit & borrow_q) | (b_bit & borrow_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      borrow_q <= 1'b0;
      hi_q     <= 1'b0;
      seen_q   <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        tick_q   <= tick_i;
        cnt_q    <= '0;
        busy_q   <= 1'b1;
        borrow_q <= 1'b0;
        hi_q     <= 1'b0;
        first_q  <= ~seen_q;
        seen_q   <= 1'b1;
      end else if (busy_q) begin
        tick_q   <= {1'b0, tick_q[TickW-1:1]};
        last_q   <= {a_bit, last_q[TickW-1:1]};
        borrow_q <= borrow_d;
        cnt_q    <= cnt_q + 1'b1;
        if (cnt_q < CntW'(FtW)) begin
          diff_q <= {d_bit, diff_q[FtW-1:1]};
        end else begin
          hi_q <= hi_q | d_bit;
        end
        if (cnt_q == CntW'(TickW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          if (first_q) begin
            ft_q <= '0;
          end else if (hi_q || d_bit) begin
            ft_q <= FtMax;
          end else begin
            ft_q <= diff_q;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign ft_o   = ft_q;

endmodule

// ===== hdl/fra_acc.sv =====
// ----------------------------------------------------------------------------
// fra_acc
// Bit-serial running sum update: add the new frame time and, once the window is full, drop the oldest.
// ----------------------------------------------------------------------------
module fra_acc import fra_pkg::*; #(
  parameter int unsigned SumW = 23
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ft_t             ft_i,
  input  ft_t             old_i,
  input  logic            full_i,
  output logic            done_o,
  output logic [SumW-1:0] sum_o
);

  localparam int unsigned CntW = $clog2(SumW);

  logic [SumW-1:0] sum_q;
  ft_t             add_q;
  ft_t             sub_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic            carry_q;
  logic            borrow_q;

  logic s_bit, f_bit, o_bit, t_bit, r_bit, carry_d, borrow_d;

  assign s_bit    = sum_q[0];
  assign f_bit    = add_q[0];
  assign o_bit    = sub_q[0];
  assign t_bit    = s_bit ^ f_bit ^ carry_q;
  assign carry_d  = (s_bit & f_bit) | (s_bit & carry_q) | (f_bit & carry_q);
  assign r_bit    = t_bit ^ o_bit ^ borrow_q;
  assign borrow_d = (~t_bit & o_bit) | (~t_bit & borrow_q) | (o_bit & borrow_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      carry_q  <= 1'b0;
      borrow_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        add_q    <= ft_i;
        sub_q    <= full_i ? old_i : '0;
        cnt_q    <= '0;
        busy_q   <= 1'b1;
        carry_q  <= 1'b0;
        borrow_q <= 1'b0;
      end else if (busy_q) begin
        sum_q    <= {r_bit, sum_q[SumW-1:1]};
        add_q    <= {1'b0, add_q[FtW-1:1]};
        sub_q    <= {1'b0, sub_q[FtW-1:1]};
        carry_q  <= carry_d;
        borrow_q <= borrow_d;
        cnt_q    <= cnt_q + 1'b1;
        if (cnt_q == CntW'(SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

endmodule

// ===== hdl/fra_div.sv =====
// ----------------------------------------------------------------------------
// fra_div
// Radix-2 restoring divider, one quotient bit per cycle; zero divisor gives 0.
// ----------------------------------------------------------------------------
module fra_div import fra_pkg::*; #(
  parameter int unsigned NumW = 25,
  parameter int unsigned DenW = 23
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW);

  logic [NumW-1:0] quot_q;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DenW:0] trial;
  logic [DenW:0] diff;
  logic          fits;

  assign trial = {rem_q, quot_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        den_q <= den_i;
        rem_q <= '0;
        cnt_q <= '0;
        if (den_i == '0) begin
          quot_q <= '0;
          done_q <= 1'b1;
        end else begin
          quot_q <= num_i;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q  <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
        quot_q <= {quot_q[NumW-2:0], fits};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/frame_rate_moving_average.sv =====
// ----------------------------------------------------------------------------
// frame_rate_moving_average
// Frame time and moving-average frame rate (Q8) from frame-end timestamps.
// Each item passes through the serial subtract, the serial sum update and the serial
// divider; when the window sum is zero the divider returns zero without iterating.
// A new timestamp is accepted only when idle, after the last one has reached the
// output register; a new item is taken while a result waits.
// Reset: asynchronous, active low; clears sum, fill count, position and first
// flag. The ring needs no clearing: an entry is used only after it is written.
// ----------------------------------------------------------------------------
module frame_rate_moving_average import fra_pkg::*; #(
  parameter int unsigned WINDOW = 100
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fra_in_if.sink       in_i,
  fra_out_if.source    out_o
);

  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam int unsigned PosW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW  = FtW + FillW;
  localparam int unsigned NumW  = $clog2(RateScale * WINDOW + 1);
  localparam int unsigned QxW   = (NumW > RateW) ? NumW : RateW;

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_ACC, S_PREP, S_DIV, S_OUT
  } state_e;

  state_e           state_q;
  ft_t              ring_q [WINDOW];
  ft_t              old_q;
  logic [PosW-1:0]  pos_q;
  logic [FillW-1:0] fill_q;
  logic             out_valid_q;
  ft_t              out_ft_q;
  rate_t            out_rate_q;

  logic            in_acc;
  logic            diff_done, acc_done, div_done;
  ft_t             ft;
  logic [SumW-1:0] sum;
  logic [NumW-1:0] num, quot;
  logic [QxW-1:0]  quot_ext;
  logic            full;
  logic            slot_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign full       = (fill_q == FillW'(WINDOW));
  assign slot_free  = !out_valid_q || out_o.ready;
  assign num        = NumW'(NumW'(fill_q) * NumW'(RateScale));
  assign quot_ext   = QxW'(quot);

  fra_diff u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .tick_i  (in_i.tick_ms),
    .done_o  (diff_done),
    .ft_o    (ft)
  );

  fra_acc #(.SumW(SumW)) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (diff_done),
    .ft_i    (ft),
    .old_i   (old_q),
    .full_i  (full),
    .done_o  (acc_done),
    .sum_o   (sum)
  );

  fra_div #(.NumW(NumW), .DenW(SumW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_PREP),
    .num_i   (num),
    .den_i   (sum),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      old_q <= ring_q[pos_q];
    end
    if (acc_done) begin
      ring_q[pos_q] <= ft;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (diff_done) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc_done) begin
            pos_q   <= (pos_q == PosW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
            fill_q  <= full ? fill_q : fill_q + 1'b1;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_ft_q    <= ft;
            out_rate_q  <= (quot_ext > QxW'(RateMax)) ? RateMax : quot_ext[RateW-1:0];
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.frame_time_ms = out_ft_q;
  assign out_o.rate_q8       = out_rate_q;

endmodule

// ===== hdl/fra_checker.sv =====
// ----------------------------------------------------------------------------
// fra_checker
// Port-level checks on the frame rate averaging block, bound to the top level.
// ----------------------------------------------------------------------------
module fra_checker import fra_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input ft_t   frame_time_i,
  input rate_t rate_i
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;
  logic       seen_out_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      seen_out_q <= 1'b0;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        seen_out_q <= 1'b1;
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_time_i) && $stable(rate_i))
    else $error("result dropped or changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result without a pending item");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !seen_out_q |-> frame_time_i == '0)
    else $error("first frame time not zero");

  a_rate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_time_i != '0 |-> rate_i != '0)
    else $error("zero rate with non-zero window sum");

endmodule

bind frame_rate_moving_average fra_checker u_fra_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .frame_time_i (out_o.frame_time_ms),
  .rate_i       (out_o.rate_q8)
);
